>>> rtl/rfp_pkg.sv
`default_nettype none
package rfp_pkg;

	// frame layout
	localparam logic [8:0] IDLEN_POS   = 9'd4;
	localparam logic [8:0] POS_MAX     = 9'd511;
	localparam logic [9:0] ID_START    = 10'd5;
	localparam logic [3:0] OFF_STAGE   = 4'd2;
	localparam logic [3:0] OFF_ERR     = 4'd10;
	localparam logic [3:0] OFF_ORIG    = 4'd12;
	localparam logic [9:0] FIELD_BYTES = 10'd16;

	// byte classes
	localparam logic [1:0] CLS_HDR = 2'd0;
	localparam logic [1:0] CLS_ID  = 2'd1;
	localparam logic [1:0] CLS_PAY = 2'd2;

	// frame status
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TOO_SMALL  = 3'd1;
	localparam logic [2:0] ST_BAD_ID_LEN = 3'd2;
	localparam logic [2:0] ST_INC_ID     = 3'd3;
	localparam logic [2:0] ST_INC_SEQ    = 3'd4;
	localparam logic [2:0] ST_INC_STAGE  = 3'd5;
	localparam logic [2:0] ST_INC_ERR    = 3'd6;
	localparam logic [2:0] ST_INC_ORIG   = 3'd7;

	// config register indexes
	localparam logic [7:0] REG_MIN_FRAME = 8'd0;
	localparam logic [7:0] REG_MAX_ID    = 8'd1;

	typedef struct packed {
		logic [7:0] min_frame;
		logic [7:0] max_id;
	} cfg_t;

	// one classified byte, front to back
	typedef struct packed {
		logic [1:0] cls;
		logic [7:0] data;
		logic       fld_wr;
		logic [3:0] fld_off;
		logic       last;
		logic [7:0] id_len;
		logic [2:0] status;
	} op_t;

endpackage
`default_nettype wire

>>> rtl/rfp_front.sv
`default_nettype none
module rfp_front
	import rfp_pkg::*;
(
	input  wire  logic       clk,
	input  wire  logic       arst_n,
	input  wire  cfg_t       cfg,
	input  wire  logic       in_valid,
	input  wire  logic [7:0] in_byte,
	input  wire  logic       in_last,
	input  wire  logic       q_ready,
	output logic             in_ready,
	output logic             q_valid,
	output op_t              q_op
);

	logic [8:0] pos_q;
	logic [7:0] id_len_q;
	logic [7:0] len_eff;
	logic       len_ok;
	logic [9:0] pos_w;
	logic [9:0] fs;
	logic [9:0] size;
	logic [9:0] off_w;
	logic       accept;

	assign in_ready = q_ready;
	assign q_valid  = in_valid;
	assign accept   = in_valid && q_ready;

	always_comb begin
		len_eff = (pos_q == IDLEN_POS) ? in_byte : id_len_q;
		len_ok  = (len_eff != 8'd0) && (len_eff <= cfg.max_id);
		pos_w   = {1'b0, pos_q};
		fs      = ID_START + {2'b00, len_eff};
		size    = pos_w + 10'd1;
		off_w   = pos_w - fs;

		q_op         = '0;
		q_op.data    = in_byte;
		q_op.last    = in_last;
		q_op.id_len  = len_eff;
		q_op.fld_off = off_w[3:0];
		q_op.cls     = CLS_HDR;
		if (pos_q > IDLEN_POS && len_ok) begin
			if (pos_w < fs)
				q_op.cls = CLS_ID;
			else if (pos_w < fs + FIELD_BYTES)
				q_op.fld_wr = 1'b1;
			else
				q_op.cls = CLS_PAY;
		end

		if (size < {2'b00, cfg.min_frame})
			q_op.status = ST_TOO_SMALL;
		else if (size <= {1'b0, IDLEN_POS} || !len_ok)
			q_op.status = ST_BAD_ID_LEN;
		else if (size < fs)
			q_op.status = ST_INC_ID;
		else if (size < fs + {6'd0, OFF_STAGE})
			q_op.status = ST_INC_SEQ;
		else if (size < fs + {6'd0, OFF_ERR})
			q_op.status = ST_INC_STAGE;
		else if (size < fs + {6'd0, OFF_ORIG})
			q_op.status = ST_INC_ERR;
		else if (size < fs + FIELD_BYTES)
			q_op.status = ST_INC_ORIG;
		else
			q_op.status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			id_len_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				pos_q    <= '0;
				id_len_q <= '0;
			end else begin
				if (pos_q == IDLEN_POS)
					id_len_q <= in_byte;
				if (pos_q != POS_MAX)
					pos_q <= pos_q + 9'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/rfp_queue.sv
`default_nettype none
module rfp_queue
	import rfp_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic wr_valid,
	input  wire  op_t  wr_op,
	output logic       wr_ready,
	output logic       rd_valid,
	output op_t        rd_op,
	input  wire  logic rd_ready
);

	op_t        mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_op    = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

>>> rtl/rfp_back.sv
`default_nettype none
module rfp_back
	import rfp_pkg::*;
(
	input  wire  logic         clk,
	input  wire  logic         arst_n,
	input  wire  logic         q_valid,
	input  wire  op_t          q_op,
	output logic               q_ready,
	output logic               out_valid,
	input  wire  logic         out_ready,
	output logic [1:0]         out_cls,
	output logic [7:0]         out_byte,
	output logic [7:0]         out_id_len,
	output logic [15:0]        out_seq,
	output logic signed [63:0] out_stage,
	output logic signed [15:0] out_err,
	output logic [31:0]        out_orig,
	output logic [2:0]         out_status,
	output logic               out_end
);

	logic [15:0] seq_q,   seq_m;
	logic [63:0] stage_q, stage_m;
	logic [15:0] err_q,   err_m;
	logic [31:0] orig_q,  orig_m;
	logic [3:0]  off;
	logic [3:0]  stage_off;
	logic [3:0]  orig_off;
	logic        pop;
	logic        emit;

	logic               valid_q;
	logic [1:0]         cls_q;
	logic [7:0]         byte_q;
	logic [7:0]         id_len_q;
	logic [15:0]        oseq_q;
	logic [63:0]        ostage_q;
	logic [15:0]        oerr_q;
	logic [31:0]        oorig_q;
	logic [2:0]         status_q;
	logic               end_q;

	assign q_ready = !valid_q || out_ready;
	assign pop     = q_valid && q_ready;
	assign off       = q_op.fld_off;
	assign stage_off = off - OFF_STAGE;
	assign orig_off  = off - OFF_ORIG;
	assign emit      = q_op.last && (q_op.status == ST_OK);

	// merge the current field byte into its lane
	always_comb begin
		seq_m   = seq_q;
		stage_m = stage_q;
		err_m   = err_q;
		orig_m  = orig_q;
		if (q_op.fld_wr) begin
			if (off < OFF_STAGE)
				seq_m[{off[0], 3'b000} +: 8] = q_op.data;
			else if (off < OFF_ERR)
				stage_m[{stage_off[2:0], 3'b000} +: 8] = q_op.data;
			else if (off < OFF_ORIG)
				err_m[{off[0], 3'b000} +: 8] = q_op.data;
			else
				orig_m[{orig_off[1:0], 3'b000} +: 8] = q_op.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= '0;
			stage_q <= '0;
			err_q   <= '0;
			orig_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (q_op.last) begin
					seq_q   <= '0;
					stage_q <= '0;
					err_q   <= '0;
					orig_q  <= '0;
				end else begin
					seq_q   <= seq_m;
					stage_q <= stage_m;
					err_q   <= err_m;
					orig_q  <= orig_m;
				end
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cls_q    <= q_op.cls;
			byte_q   <= q_op.data;
			end_q    <= q_op.last;
			status_q <= q_op.last ? q_op.status : ST_OK;
			id_len_q <= emit ? q_op.id_len : 8'd0;
			oseq_q   <= emit ? seq_m : 16'd0;
			ostage_q <= emit ? stage_m : 64'd0;
			oerr_q   <= emit ? err_m : 16'd0;
			oorig_q  <= emit ? orig_m : 32'd0;
		end
	end

	assign out_valid  = valid_q;
	assign out_cls    = cls_q;
	assign out_byte   = byte_q;
	assign out_id_len = id_len_q;
	assign out_seq    = oseq_q;
	assign out_stage  = $signed(ostage_q);
	assign out_err    = $signed(oerr_q);
	assign out_orig   = oorig_q;
	assign out_status = status_q;
	assign out_end    = end_q;

endmodule
`default_nettype wire

>>> rtl/response_frame_parser_top.sv
// Response frame parser.
// s_* carries one frame byte per beat, s_tlast on the final byte.
// Each input beat yields exactly one m_* beat: m_tuser classes the byte
// (header/dropped, id, payload) and m_tdata carries it through. On the
// beat with m_tlast set, m_tdata also holds id length, sequence, stage,
// error code, original size and a status; these read zero otherwise, and all
// but the status also read zero when the status is not ok.
// cfg_* writes min_frame_size (index 0) and max_id_length (index 1);
// cfg_ready is always high.
// A byte accepted into the queue is registered there and then in the output
// register before it is presented on m_*. Throughput: one byte per cycle
// while m_tready stays high; a front stage tracks position and classifies,
// a two-entry queue feeds the back stage that assembles fields into an
// output register.
// When m_tready is low the output register holds, the queue fills and
// s_tready drops once both queue entries are held; no beat is lost.
// Reset clears position, id length, fields, queue and output valid, and
// loads min_frame_size = 21, max_id_length = 255.
`default_nettype none
module response_frame_parser_top
	import rfp_pkg::*;
(
	input  wire  logic         clk,
	input  wire  logic         arst_n,
	input  wire  logic         s_tvalid,
	output logic               s_tready,
	input  wire  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  wire  logic         s_tlast,
	output logic               m_tvalid,
	input  wire  logic         m_tready,
	// [7:0] out_byte, [15:8] id_length, [31:16] sequence_res, [95:32] stage,
	// [111:96] response_error, [143:112] original_length, [146:144] status
	output logic [151:0]       m_tdata,
	output logic [1:0]         m_tuser,   // [1:0] byte_class
	output logic               m_tlast,
	input  wire  logic         cfg_valid,
	output logic               cfg_ready,
	input  wire  logic [7:0]   cfg_index,
	input  wire  logic [7:0]   cfg_data
);

	cfg_t cfg_q;
	logic f_valid, f_ready;
	op_t  f_op;
	logic b_valid, b_ready;
	op_t  b_op;

	logic [7:0]         o_byte, o_id_len;
	logic [15:0]        o_seq;
	logic signed [63:0] o_stage;
	logic signed [15:0] o_err;
	logic [31:0]        o_orig;
	logic [2:0]         o_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_frame <= 8'd21;
			cfg_q.max_id    <= 8'd255;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_FRAME: cfg_q.min_frame <= cfg_data;
				REG_MAX_ID:    cfg_q.max_id    <= cfg_data;
				default: ;
			endcase
		end
	end

	rfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_ready  (f_ready),
		.in_ready (s_tready),
		.q_valid  (f_valid),
		.q_op     (f_op)
	);

	rfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_op    (f_op),
		.wr_ready (f_ready),
		.rd_valid (b_valid),
		.rd_op    (b_op),
		.rd_ready (b_ready)
	);

	rfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (b_valid),
		.q_op       (b_op),
		.q_ready    (b_ready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_cls    (m_tuser),
		.out_byte   (o_byte),
		.out_id_len (o_id_len),
		.out_seq    (o_seq),
		.out_stage  (o_stage),
		.out_err    (o_err),
		.out_orig   (o_orig),
		.out_status (o_status),
		.out_end    (m_tlast)
	);

	assign m_tdata = {5'd0, o_status, o_orig, o_err, o_stage, o_seq, o_id_len, o_byte};

endmodule
`default_nettype wire

>>> rtl/rfp_checker.sv
`default_nettype none
module rfp_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [151:0] m_tdata,
	input wire logic [1:0]   m_tuser,
	input wire logic         m_tlast
);

	// mid-frame beats carry no status
	a_no_status_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[146:144] == 3'd0)
		else $error("status set on a beat that does not end a frame");

	// failed frames report no parsed fields
	a_fields_zero_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tdata[146:144] != 3'd0 |-> m_tdata[143:8] == '0)
		else $error("parsed fields nonzero on a failed frame");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3)
		else $error("byte class out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

endmodule

bind response_frame_parser_top rfp_checker u_rfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
